// ===== src/scg_pkg.sv =====
// Shared types, constants and the quarter-wave table builder for the sine/cosine generator.
package scg_pkg;

  localparam int WORD_BITS      = 32;
  localparam int AMP_BITS       = 16;
  localparam int AMP_FRAC_BITS  = 12;
  localparam int LENGTH_BITS    = 24;
  localparam int SAMPLE_BITS    = 20;
  localparam int ENTRY_BITS     = 15;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [AMP_BITS-1:0]    AMP_RESET    = AMP_BITS'(4096);
  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(1024);
  localparam logic [63:0]            HALF_PI_Q30  = 64'd1686629713;
  localparam logic [ENTRY_BITS-1:0]  ENTRY_MAX    = ENTRY_BITS'(32767);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FREQUENCY    = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_BLOCK_LENGTH = 3'd3,
    REG_COMPLEX_MODE = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   frequency_word;
    logic [WORD_BITS-1:0]   phase_offset;
    logic [AMP_BITS-1:0]    amplitude;
    logic [LENGTH_BITS-1:0] block_length;
    logic                   complex_mode;
  } cfg_t;

  typedef struct packed {
    logic                   bad;
    logic                   last;
    logic [LENGTH_BITS-1:0] index;
  } ctl_t;

  // Entry k of a quarter-wave table with 2^tb steps, built from an integer
  // Taylor series in Q30. Evaluated at elaboration only.
  function automatic logic [ENTRY_BITS-1:0] table_entry(input int unsigned k,
                                                        input int unsigned tb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    logic [63:0]        e;
    x = (HALF_PI_Q30 * 64'(k) + ((64'd1 << tb) >> 1)) >> tb;
    x2 = (x * x) >> 30;
    term = x;
    sum = '0;
    for (int n = 0; n < 8; n++) begin
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
      prod = (term * x2) >> 30;
      case (n)
        0: term = prod / 64'd6;
        1: term = prod / 64'd20;
        2: term = prod / 64'd42;
        3: term = prod / 64'd72;
        4: term = prod / 64'd110;
        5: term = prod / 64'd156;
        6: term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
    end
    if (sum < 0) sum = '0;
    e = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'(ENTRY_MAX)) e = 64'(ENTRY_MAX);
    return e[ENTRY_BITS-1:0];
  endfunction

endpackage

// ===== src/scg_front.sv =====
// Front end: accepts restart beats, runs the phase accumulator and block counter.
module scg_front #(
  parameter int TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    restart,
  input  scg_pkg::cfg_t           cfg,
  input  logic                    queue_full,
  output logic                    push,
  output logic [TABLE_BITS+1:0]   push_phase,
  output scg_pkg::ctl_t           push_ctl
);

  logic [PHASE_BITS-1:0]           phase_acc;
  logic [PHASE_BITS-1:0]           phase_acc_next;
  logic [scg_pkg::LENGTH_BITS-1:0] sample_counter;
  logic [scg_pkg::LENGTH_BITS-1:0] sample_counter_next;

  logic [scg_pkg::LENGTH_BITS-1:0] cnt;
  logic [scg_pkg::LENGTH_BITS-1:0] len;
  logic [scg_pkg::LENGTH_BITS:0]   cnt_inc;
  logic [PHASE_BITS-1:0]           phase;
  logic                            last;

  assign item_ready = !queue_full;
  assign push       = item_valid && item_ready;

  always_comb begin
    cnt     = restart ? '0 : sample_counter;
    // A new block reloads the phase from the offset register.
    phase   = (cnt == '0) ? PHASE_BITS'(cfg.phase_offset) : phase_acc;
    len     = (cfg.block_length == '0) ? scg_pkg::LENGTH_BITS'(1) : cfg.block_length;
    cnt_inc = {1'b0, cnt} + (scg_pkg::LENGTH_BITS+1)'(1);
    last    = (cnt_inc >= {1'b0, len});
    sample_counter_next = last ? '0 : cnt_inc[scg_pkg::LENGTH_BITS-1:0];
    phase_acc_next      = phase + PHASE_BITS'(cfg.frequency_word);
  end

  assign push_phase     = phase[PHASE_BITS-1 -: TABLE_BITS+2];
  assign push_ctl.bad   = (cfg.frequency_word == '0);
  assign push_ctl.last  = last;
  assign push_ctl.index = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc      <= '0;
      sample_counter <= '0;
    end else if (push) begin
      phase_acc      <= phase_acc_next;
      sample_counter <= sample_counter_next;
    end
  end

endmodule

// ===== src/scg_queue.sv =====
// Small FIFO between the front end and the sample pipeline.
module scg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == COUNT_BITS'(DEPTH));
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + COUNT_BITS'(1);
        2'b01:   count <= count - COUNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/scg_rom.sv =====
// Quarter-wave sine table with two registered read ports.
module scg_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [TABLE_BITS:0]            addr_a,
  input  logic [TABLE_BITS:0]            addr_b,
  output logic [scg_pkg::ENTRY_BITS-1:0] data_a,
  output logic [scg_pkg::ENTRY_BITS-1:0] data_b
);

  localparam int ENTRIES = 2**TABLE_BITS + 1;

  logic [scg_pkg::ENTRY_BITS-1:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    assign rom[k] = scg_pkg::table_entry(32'(k), 32'(TABLE_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

// ===== src/scg_back.sv =====
// Back end: table lookup, amplitude multiply, rounding and the output register.
module scg_back #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  scg_pkg::cfg_t                         cfg,
  input  logic                                  queue_empty,
  input  logic [TABLE_BITS+1:0]                 pop_phase,
  input  scg_pkg::ctl_t                         pop_ctl,
  output logic                                  pop,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [scg_pkg::SAMPLE_BITS-1:0] sine_value,
  output logic signed [scg_pkg::SAMPLE_BITS-1:0] cosine_value,
  output logic [scg_pkg::LENGTH_BITS-1:0]       sample_index,
  output logic                                  block_end,
  output logic                                  bad_frequency
);

  localparam int PROD_BITS = scg_pkg::ENTRY_BITS + scg_pkg::AMP_BITS;
  localparam logic [TABLE_BITS:0] QUARTER = {1'b1, {TABLE_BITS{1'b0}}};
  localparam logic [PROD_BITS:0]  HALF_LSB = (PROD_BITS+1)'(1) << (scg_pkg::AMP_FRAC_BITS - 1);

  logic                           en;
  logic [1:0]                     quad;
  logic [TABLE_BITS:0]            idx;
  logic [TABLE_BITS:0]            sin_addr;
  logic [TABLE_BITS:0]            cos_addr;
  logic [scg_pkg::ENTRY_BITS-1:0] sin_mag;
  logic [scg_pkg::ENTRY_BITS-1:0] cos_mag;

  logic                 a_valid;
  scg_pkg::ctl_t        a_ctl;
  logic                 a_sin_neg;
  logic                 a_cos_neg;

  logic                 b_valid;
  scg_pkg::ctl_t        b_ctl;
  logic                 b_sin_neg;
  logic                 b_cos_neg;
  logic [PROD_BITS-1:0] b_sin_prod;
  logic [PROD_BITS-1:0] b_cos_prod;

  logic [PROD_BITS:0]              sin_rnd;
  logic [PROD_BITS:0]              cos_rnd;
  logic [scg_pkg::SAMPLE_BITS-1:0] sin_mag_out;
  logic [scg_pkg::SAMPLE_BITS-1:0] cos_mag_out;
  logic [scg_pkg::SAMPLE_BITS-1:0] sin_out;
  logic [scg_pkg::SAMPLE_BITS-1:0] cos_out;

  // The whole pipeline moves together; the queue absorbs the slack.
  assign en  = !result_valid || result_ready;
  assign pop = en && !queue_empty;

  // Odd quadrants read the table mirrored; the cosine sits one quadrant ahead.
  assign quad     = pop_phase[TABLE_BITS+1 -: 2];
  assign idx      = {1'b0, pop_phase[TABLE_BITS-1:0]};
  assign sin_addr = quad[0] ? (QUARTER - idx) : idx;
  assign cos_addr = quad[0] ? idx : (QUARTER - idx);

  scg_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en),
    .addr_a (sin_addr),
    .addr_b (cos_addr),
    .data_a (sin_mag),
    .data_b (cos_mag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl      <= pop_ctl;
      a_sin_neg  <= quad[1];
      a_cos_neg  <= quad[1] ^ quad[0];
      b_ctl      <= a_ctl;
      b_sin_neg  <= a_sin_neg;
      b_cos_neg  <= a_cos_neg;
      b_sin_prod <= PROD_BITS'(sin_mag) * PROD_BITS'(cfg.amplitude);
      b_cos_prod <= PROD_BITS'(cos_mag) * PROD_BITS'(cfg.amplitude);
    end
  end

  always_comb begin
    sin_rnd     = {1'b0, b_sin_prod} + HALF_LSB;
    cos_rnd     = {1'b0, b_cos_prod} + HALF_LSB;
    sin_mag_out = sin_rnd[scg_pkg::AMP_FRAC_BITS +: scg_pkg::SAMPLE_BITS];
    cos_mag_out = cos_rnd[scg_pkg::AMP_FRAC_BITS +: scg_pkg::SAMPLE_BITS];
    sin_out     = b_sin_neg ? ('0 - sin_mag_out) : sin_mag_out;
    cos_out     = b_cos_neg ? ('0 - cos_mag_out) : cos_mag_out;
    if (b_ctl.bad) begin
      sin_out = '0;
      cos_out = '0;
    end
    if (!cfg.complex_mode) cos_out = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_value    <= $signed(sin_out);
      cosine_value  <= $signed(cos_out);
      sample_index  <= b_ctl.index;
      block_end     <= b_ctl.last;
      bad_frequency <= b_ctl.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      a_valid      <= pop;
      b_valid      <= a_valid;
      result_valid <= b_valid;
    end
  end

endmodule

// ===== src/sine_cosine_generator.sv =====
// Top level of the numerically controlled sine/cosine oscillator.
//
// Usage: each beat on the item channel (item_valid/item_ready, field restart)
// asks for one sample; each beat on the result channel carries it back with
// sine_value, cosine_value, sample_index, block_end and bad_frequency.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while the block is idle.
// Throughput is one sample per clock while result_ready is not held low: the
// front end updates the phase accumulator and block counter in the cycle a beat
// is accepted, and the back end pipeline (table read, amplitude multiply,
// rounding register) takes one sample per cycle. An accepted item beat is
// written into the queue at the accepting edge, then passes the registered
// table read, the registered product and the output register before its
// result beat is valid.
// When the receiver holds result_ready low the back end freezes as a whole
// and a four-entry queue soaks up items already accepted; item_ready drops
// only once that queue is full. Synchronous reset clears the accumulator,
// counter, queue and valid flags and loads the register reset values
// (unity amplitude, block length 1024, sine only, zero frequency word).
module sine_cosine_generator #(
  parameter int TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  logic                                   restart,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [scg_pkg::SAMPLE_BITS-1:0] sine_value,
  output logic signed [scg_pkg::SAMPLE_BITS-1:0] cosine_value,
  output logic [scg_pkg::LENGTH_BITS-1:0]        sample_index,
  output logic                                   block_end,
  output logic                                   bad_frequency,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [scg_pkg::WORD_BITS-1:0]          cfg_data
);

  localparam int QUEUE_DEPTH = 4;
  localparam int ENTRY_WIDTH = TABLE_BITS + 2 + $bits(scg_pkg::ctl_t);

  scg_pkg::cfg_t         cfg;
  logic                  push;
  logic [TABLE_BITS+1:0] push_phase;
  scg_pkg::ctl_t         push_ctl;
  logic                  pop;
  logic [ENTRY_WIDTH-1:0] pop_data;
  logic                  queue_empty;
  logic                  queue_full;
  logic [TABLE_BITS+1:0] pop_phase;
  scg_pkg::ctl_t         pop_ctl;

  // Register file. Unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frequency_word <= '0;
      cfg.phase_offset   <= '0;
      cfg.amplitude      <= scg_pkg::AMP_RESET;
      cfg.block_length   <= scg_pkg::LENGTH_RESET;
      cfg.complex_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scg_pkg::REG_FREQUENCY:    cfg.frequency_word <= cfg_data;
        scg_pkg::REG_PHASE_OFFSET: cfg.phase_offset   <= cfg_data;
        scg_pkg::REG_AMPLITUDE:    cfg.amplitude      <= cfg_data[scg_pkg::AMP_BITS-1:0];
        scg_pkg::REG_BLOCK_LENGTH: cfg.block_length   <= cfg_data[scg_pkg::LENGTH_BITS-1:0];
        scg_pkg::REG_COMPLEX_MODE: cfg.complex_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  scg_front #(
    .TABLE_BITS(TABLE_BITS),
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .restart    (restart),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_phase (push_phase),
    .push_ctl   (push_ctl)
  );

  scg_queue #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_phase, push_ctl}),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  assign pop_phase = pop_data[ENTRY_WIDTH-1 -: TABLE_BITS+2];
  assign pop_ctl   = pop_data[$bits(scg_pkg::ctl_t)-1:0];

  scg_back #(
    .TABLE_BITS(TABLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .queue_empty   (queue_empty),
    .pop_phase     (pop_phase),
    .pop_ctl       (pop_ctl),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .sine_value    (sine_value),
    .cosine_value  (cosine_value),
    .sample_index  (sample_index),
    .block_end     (block_end),
    .bad_frequency (bad_frequency)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sine/cosine oscillator: random beats on both channels.
module tb_top;

  // The predictor keeps its own quarter-wave table, at the block's default size.
  localparam int                  WAVE_BITS            = 10;
  localparam int                  WAVE_STEPS           = 1 << WAVE_BITS;
  localparam logic [63:0]         QUARTER_TURN_RAD_Q30 = 64'd1686629713;
  localparam logic [scg_pkg::WORD_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [scg_pkg::CFG_INDEX_BITS-1:0] FIRST_UNUSED_REG =
    scg_pkg::CFG_INDEX_BITS'(scg_pkg::REG_COMPLEX_MODE + 1);
  localparam int RX_HOLD_CYCLES = 60;
  localparam int REPORT_LIMIT   = 10;

  // One output beat, laid out in the same order as the result ports.
  typedef struct packed {
    logic signed [scg_pkg::SAMPLE_BITS-1:0] sine;
    logic signed [scg_pkg::SAMPLE_BITS-1:0] cosine;
    logic [scg_pkg::LENGTH_BITS-1:0]        index;
    logic                                   last;
    logic                                   bad;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                   item_valid = 1'b0;
  logic                                   item_ready;
  logic                                   restart = 1'b0;
  logic                                   result_valid;
  logic                                   result_ready = 1'b0;
  logic signed [scg_pkg::SAMPLE_BITS-1:0] sine_value;
  logic signed [scg_pkg::SAMPLE_BITS-1:0] cosine_value;
  logic [scg_pkg::LENGTH_BITS-1:0]        sample_index;
  logic                                   block_end;
  logic                                   bad_frequency;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [scg_pkg::CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [scg_pkg::WORD_BITS-1:0]          cfg_data = '0;

  // Predictor state: register copy, phase accumulator and position in the block.
  int                              quarter_wave [0:WAVE_STEPS];
  scg_pkg::cfg_t                   nco_cfg;
  logic [scg_pkg::WORD_BITS-1:0]   nco_phase;
  logic [scg_pkg::LENGTH_BITS-1:0] nco_count;

  bit      pending_restarts [$];
  sample_t expected_samples [$];
  sample_t got;
  sample_t want;

  int errors           = 0;
  int send_idle_pct    = 17;
  int rx_idle_pct      = 17;
  int rx_hold_requests = 0;
  int rx_holds_served  = 0;
  int rx_hold_left     = 0;

  sine_cosine_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sine_value   (sine_value),
    .cosine_value (cosine_value),
    .sample_index (sample_index),
    .block_end    (block_end),
    .bad_frequency(bad_frequency),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Signed table value at a phase. The top two bits pick the quadrant; odd
  // quadrants read the table backward, the upper half of the turn is negated.
  function automatic int wave_at(input logic [scg_pkg::WORD_BITS-1:0] phase);
    int unsigned step;
    int          v;
    step = phase[scg_pkg::WORD_BITS-3 -: WAVE_BITS];
    v = phase[scg_pkg::WORD_BITS-2] ? quarter_wave[WAVE_STEPS - step] : quarter_wave[step];
    return phase[scg_pkg::WORD_BITS-1] ? -v : v;
  endfunction

  // Q1.15 times Q4.12 amplitude, rounded on the magnitude so that ties go away
  // from zero, then the sign is put back.
  function automatic logic [scg_pkg::SAMPLE_BITS-1:0] scaled(input int s);
    longint unsigned mag;
    longint unsigned r;
    mag = longint'((s < 0) ? -s : s);
    r = (mag * nco_cfg.amplitude + 64'd2048) >> scg_pkg::AMP_FRAC_BITS;
    return (s < 0) ? scg_pkg::SAMPLE_BITS'(-r) : scg_pkg::SAMPLE_BITS'(r);
  endfunction

  // Advances the oscillator by one beat and returns the sample it must give.
  function automatic sample_t next_sample(input logic restart_bit);
    sample_t                       s;
    logic [scg_pkg::LENGTH_BITS:0] len;
    len = (nco_cfg.block_length == '0) ? (scg_pkg::LENGTH_BITS+1)'(1)
                                       : {1'b0, nco_cfg.block_length};
    if (restart_bit) nco_count = '0;
    // A new block always starts from the phase offset.
    if (nco_count == '0) nco_phase = nco_cfg.phase_offset;
    s.bad = (nco_cfg.frequency_word == '0);
    if (s.bad) begin
      s.sine   = '0;
      s.cosine = '0;
    end else begin
      s.sine   = scaled(wave_at(nco_phase));
      s.cosine = nco_cfg.complex_mode ? scaled(wave_at(nco_phase + QUARTER_TURN)) : '0;
    end
    s.index = nco_count;
    s.last = ({1'b0, nco_count} + (scg_pkg::LENGTH_BITS+1)'(1) >= len);
    nco_count = s.last ? '0 : nco_count + 1'b1;
    nco_phase = nco_phase + nco_cfg.frequency_word;
    return s;
  endfunction

  // Writes one register and mirrors it into the predictor's copy. Indexes that
  // name no register leave everything as it was.
  task automatic write_reg(input logic [scg_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [scg_pkg::WORD_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      scg_pkg::REG_FREQUENCY:    nco_cfg.frequency_word = value;
      scg_pkg::REG_PHASE_OFFSET: nco_cfg.phase_offset   = value;
      scg_pkg::REG_AMPLITUDE:    nco_cfg.amplitude      = value[scg_pkg::AMP_BITS-1:0];
      scg_pkg::REG_BLOCK_LENGTH: nco_cfg.block_length   = value[scg_pkg::LENGTH_BITS-1:0];
      scg_pkg::REG_COMPLEX_MODE: nco_cfg.complex_mode   = value[0];
      default: ;
    endcase
  endtask

  // Waits until every queued item has been taken and every sample has come
  // back, then lets the pipeline settle before registers may change. The
  // checks are made on the falling edge, where the sender's state is settled.
  task automatic wait_drained();
    while (pending_restarts.size() != 0 || item_valid) @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sender. A beat is predicted at the edge where it is taken, so the
  // predictor sees beats in exactly the order the block does. A new beat is
  // offered only once the previous one has gone, and the payload holds meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      restart    <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_samples.push_back(next_sample(restart));
      end
      if (!item_valid || item_ready) begin
        if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          restart    <= pending_restarts.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Normally it stalls at random; when a hold-off is requested it
  // keeps ready low for a fixed count of cycles so that the block backs up and
  // has to drop item_ready.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      result_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_holds_served != rx_hold_requests) begin
      result_ready    <= 1'b0;
      rx_holds_served <= rx_holds_served + 1;
      rx_hold_left    <= RX_HOLD_CYCLES;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checker. Every result beat is matched against the oldest prediction;
  // the four-state compare also catches unknown bits on the outputs.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got = {sine_value, cosine_value, sample_index, block_end, bad_frequency};
      if (expected_samples.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("Result beat with nothing expected: sine %0d cosine %0d index %0d",
                   $signed(got.sine), $signed(got.cosine), got.index);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          if (errors < REPORT_LIMIT) begin
            $display("Sample mismatch, expected sine %0d cosine %0d index %0d end %0b bad %0b",
                     $signed(want.sine), $signed(want.cosine), want.index, want.last,
                     want.bad);
            $display("                  actual sine %0d cosine %0d index %0d end %0b bad %0b",
                     $signed(got.sine), $signed(got.cosine), got.index, got.last, got.bad);
          end
          errors++;
        end
      end
    end
  end

  // Stimulus sequence: a short directed part, then random phases, each with
  // fresh register settings written while the block is idle.
  initial begin
    int unsigned     k;
    int unsigned     n;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned e;
    longint          acc;
    int              phase_no;
    logic [scg_pkg::WORD_BITS-1:0] word;

    // Quarter-wave table: eight Taylor terms of the sine in Q30, then rounded
    // to Q1.15 and capped at the largest positive entry.
    for (k = 0; k <= WAVE_STEPS; k++) begin
      x = (QUARTER_TURN_RAD_Q30 * k + (WAVE_STEPS / 2)) >> WAVE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      acc = 0;
      for (n = 0; n < 8; n++) begin
        if (n % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
        term = ((term * x2) >> 30) / ((2 * n + 2) * (2 * n + 3));
      end
      if (acc < 0) acc = 0;
      e = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) e = 64'd32767;
      quarter_wave[k] = int'(e);
    end

    nco_cfg.frequency_word = '0;
    nco_cfg.phase_offset   = '0;
    nco_cfg.amplitude      = scg_pkg::AMP_RESET;
    nco_cfg.block_length   = scg_pkg::LENGTH_RESET;
    nco_cfg.complex_mode   = 1'b0;
    nco_phase = '0;
    nco_count = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the frequency word is zero, so every sample is flagged bad
    // and zero while the block counter still runs.
    pending_restarts = '{1'b0, 1'b1, 1'b0};
    wait_drained();

    // Quarter-turn steps walk through all four quadrants, including the table
    // ends, with a four-sample block so the phase restarts on the fifth.
    write_reg(scg_pkg::REG_FREQUENCY, QUARTER_TURN);
    write_reg(scg_pkg::REG_PHASE_OFFSET, '0);
    write_reg(scg_pkg::REG_AMPLITUDE, 32'd4096);
    write_reg(scg_pkg::REG_BLOCK_LENGTH, 32'd4);
    write_reg(scg_pkg::REG_COMPLEX_MODE, 32'd1);
    pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_drained();

    // Largest gain, all-ones phase and step, and a zero block length, which
    // behaves as a length of one so every sample ends its block.
    write_reg(scg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(scg_pkg::REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    write_reg(scg_pkg::REG_FREQUENCY, 32'hFFFF_FFFF);
    write_reg(scg_pkg::REG_BLOCK_LENGTH, 32'hFF00_0000);
    pending_restarts = '{1'b0, 1'b0, 1'b1};
    wait_drained();

    // Half gain lands odd table entries exactly on a rounding tie; the longest
    // block keeps the counter running across beats.
    write_reg(scg_pkg::REG_AMPLITUDE, 32'd2048);
    write_reg(scg_pkg::REG_FREQUENCY, 32'h0010_0000);
    write_reg(scg_pkg::REG_BLOCK_LENGTH, 32'hFFFF_FFFF);
    write_reg(scg_pkg::REG_COMPLEX_MODE, 32'hFFFF_FFFE);
    pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0};
    wait_drained();

    // Zero gain, and writes to indexes that hold no register.
    write_reg(scg_pkg::REG_AMPLITUDE, 32'hFFFF_0000);
    write_reg(FIRST_UNUSED_REG, 32'hFFFF_FFFF);
    write_reg(scg_pkg::CFG_INDEX_BITS'(FIRST_UNUSED_REG + 2), 32'h0000_0000);
    pending_restarts = '{1'b0, 1'b0};
    wait_drained();

    for (phase_no = 0; phase_no < 10; phase_no++) begin
      // One phase runs with no idling at all; another holds the receiver off
      // while the sender streams, so the block fills and stalls its input.
      send_idle_pct = (phase_no == 3 || phase_no == 6) ? 0 : 17;
      rx_idle_pct   = (phase_no == 3) ? 0 : 17;

      if ($urandom_range(4) != 0) begin
        case ($urandom_range(9))
          0:       word = '0;
          1:       word = $urandom_range(255);
          2:       word = ~scg_pkg::WORD_BITS'($urandom_range(255));
          default: word = $urandom;
        endcase
        write_reg(scg_pkg::REG_FREQUENCY, word);
      end
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(5))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        write_reg(scg_pkg::REG_PHASE_OFFSET, word);
      end
      if ($urandom_range(4) != 0) begin
        word = $urandom;
        case ($urandom_range(5))
          0: word[scg_pkg::AMP_BITS-1:0] = '0;
          1: word[scg_pkg::AMP_BITS-1:0] = '1;
          2: word[scg_pkg::AMP_BITS-1:0] = 16'd4096;
          3: word[scg_pkg::AMP_BITS-1:0] = 16'd2048;
          default: ;
        endcase
        write_reg(scg_pkg::REG_AMPLITUDE, word);
      end
      if ($urandom_range(4) != 0) begin
        word = $urandom;
        case ($urandom_range(9))
          0:       word[scg_pkg::LENGTH_BITS-1:0] = '0;
          1:       word[scg_pkg::LENGTH_BITS-1:0] = 24'd1;
          2:       word[scg_pkg::LENGTH_BITS-1:0] = '1;
          3:       ;
          default: word[scg_pkg::LENGTH_BITS-1:0] =
                     scg_pkg::LENGTH_BITS'($urandom_range(48, 2));
        endcase
        write_reg(scg_pkg::REG_BLOCK_LENGTH, word);
      end
      if ($urandom_range(4) != 0) write_reg(scg_pkg::REG_COMPLEX_MODE, $urandom);
      if ($urandom_range(3) == 0)
        write_reg(scg_pkg::CFG_INDEX_BITS'(FIRST_UNUSED_REG + $urandom_range(2)), $urandom);

      if (phase_no == 6) rx_hold_requests++;
      repeat (120) pending_restarts.push_back($urandom_range(7) == 0);
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // A correct run finishes long before this timeout.
  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
